// File: rtl/sbfb_pkg.sv
// sbfb_pkg: types, constants and opcode tables for the servo bus frame builder
// no dependencies; imported by servo_bus_frame_builder
package sbfb_pkg;

	localparam int MAX_LEN     = 60;
	localparam int STORE_DEPTH = MAX_LEN + 4;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FILL_W      = ADDR_W + 1;

	localparam logic [7:0] ALL_CALL_ID  = 8'hFE;
	localparam logic [7:0] SYNC_INSTR   = 8'h83;
	localparam logic [7:0] HDR_BYTE     = 8'hFF;

	localparam logic [7:0] INS_NONE   = 8'h00;
	localparam logic [7:0] INS_PING   = 8'h01;
	localparam logic [7:0] INS_READ   = 8'h02;
	localparam logic [7:0] INS_WRITE  = 8'h03;
	localparam logic [7:0] INS_REGW   = 8'h04;
	localparam logic [7:0] INS_ACTION = 8'h05;
	localparam logic [7:0] INS_RESET  = 8'h06;

	localparam logic [2:0] OP_PING   = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_REGW   = 3'd3;
	localparam logic [2:0] OP_ACTION = 3'd4;
	localparam logic [2:0] OP_RESET  = 3'd5;
	localparam logic [2:0] OP_SYNC   = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] servo_id;
		logic [7:0] reg_addr;
		logic [7:0] data_len;
		logic [7:0] data_byte;
		logic       record_start;
		logic       command_last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic [1:0] status;
		logic       frame_end;
	} rsp_t;

	function automatic logic [7:0] instr_code(input logic [2:0] op);
		logic [7:0] code;
		case (op)
			OP_PING:   code = INS_PING;
			OP_READ:   code = INS_READ;
			OP_WRITE:  code = INS_WRITE;
			OP_REGW:   code = INS_REGW;
			OP_ACTION: code = INS_ACTION;
			OP_RESET:  code = INS_RESET;
			OP_SYNC:   code = SYNC_INSTR;
			default:   code = INS_NONE;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/sbfb_ram.sv
// sbfb_ram: generic single write port, single read port ram with registered read
// no dependencies
module sbfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/servo_bus_frame_builder.sv
// servo_bus_frame_builder: smart-servo instruction frame builder, top level
// depends on sbfb_pkg and sbfb_ram (parameter byte store)
//
// channel   ports                  handshake
// command   cmd (cmd_t)            word taken when start high and busy low
// result    result (rsp_t)         one word per cycle while strobe is high
//
// an item stores at most four bytes in the byte store
// a closing item sizes the frame in the multiply and decode states, then one word per cycle
// for the whole frame (up to 64 words), read through the registered store
// an error closes with a single word; the byte store needs no clearing after reset
// the receiver cannot stall; busy stays high until the last word is registered into result
module servo_bus_frame_builder
	import sbfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic strobe,
	output rsp_t result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUT  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [FILL_W-1:0] fp_q;
	logic [7:0]        sum_q;
	logic [7:0]        first_reg_q;
	logic [7:0]        first_len_q;
	logic [6:0]        rc_q;
	logic [7:0]        bir_q;
	logic              err_q;
	logic [2:0]        op_q;
	logic [7:0]        id_q;
	logic              last_q;
	logic [3:0]        mask_q;
	cmd_t              word_q;
	logic [15:0]       prod_q;
	logic [ADDR_W-1:0] flen_q;
	logic [ADDR_W-1:0] e_q;
	logic              v_s1;
	logic [ADDR_W-1:0] idx_s1;

	logic              accept;
	logic              idle_c;
	logic [2:0]        op_e;
	logic [6:0]        rc_e;
	logic [6:0]        rc_a;
	logic [7:0]        flr_e;
	logic [7:0]        fln_e;
	logic [7:0]        fln_a;
	logic [7:0]        bir_e;
	logic [7:0]        bir_a;
	logic              err_e;
	logic              sync_rs;
	logic              new_rec;
	logic [3:0]        mask_c;
	logic [7:0]        hdr_id;

	logic [7:0]        put_byte;
	logic [3:0]        mask_nxt;
	logic              we;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	logic [15:0]       flen_c;
	logic [1:0]        stat_c;
	logic [8:0]        lenp1;
	logic [ADDR_W-1:0] last_idx;
	logic [7:0]        byte_c;
	logic              err_word;

	assign busy   = (state_q != S_IDLE) || v_s1;
	assign accept = start && !busy;

	// item decode against the state it meets, with a fresh command starting from idle
	always_comb begin
		idle_c  = (fp_q == '0);
		op_e    = idle_c ? cmd.operation : op_q;
		rc_e    = (idle_c && (cmd.operation == OP_WRITE || cmd.operation == OP_REGW)) ? 7'd1 :
		          (idle_c ? 7'd0 : rc_q);
		flr_e   = idle_c ? ((cmd.operation == OP_WRITE || cmd.operation == OP_REGW) ?
		          cmd.reg_addr : 8'd0) : first_reg_q;
		fln_e   = idle_c ? ((cmd.operation == OP_WRITE || cmd.operation == OP_REGW) ?
		          cmd.data_len : 8'd0) : first_len_q;
		bir_e   = idle_c ? 8'd0 : bir_q;
		err_e   = idle_c ? (instr_code(cmd.operation) == INS_NONE) : err_q;
		sync_rs = (op_e == OP_SYNC) && cmd.record_start;
		new_rec = sync_rs && (rc_e == 7'd0);
		rc_a    = sync_rs ? ((rc_e < 7'd127) ? rc_e + 7'd1 : rc_e) : rc_e;
		fln_a   = new_rec ? cmd.data_len : fln_e;
		bir_a   = sync_rs ? 8'd0 : bir_e;
		hdr_id  = (cmd.operation == OP_SYNC) ? ALL_CALL_ID : cmd.servo_id;
		mask_c[0] = (idle_c && (cmd.operation == OP_READ || cmd.operation == OP_WRITE ||
		            cmd.operation == OP_REGW)) || new_rec;
		mask_c[1] = (idle_c && cmd.operation == OP_READ) || new_rec;
		mask_c[2] = sync_rs;
		mask_c[3] = (op_e == OP_WRITE || op_e == OP_REGW || op_e == OP_SYNC) &&
		            (rc_a != 7'd0) && (bir_a < fln_a);
	end

	// shared put unit: lowest pending slot in reg, len, id, data order
	always_comb begin
		mask_nxt = mask_q;
		put_byte = word_q.data_byte;
		if (mask_q[0]) begin
			put_byte    = word_q.reg_addr;
			mask_nxt[0] = 1'b0;
		end else if (mask_q[1]) begin
			put_byte    = word_q.data_len;
			mask_nxt[1] = 1'b0;
		end else if (mask_q[2]) begin
			put_byte    = word_q.servo_id;
			mask_nxt[2] = 1'b0;
		end else begin
			mask_nxt[3] = 1'b0;
		end
		we = (state_q == S_PUT) && (mask_q != 4'd0) && (fp_q < FILL_W'(STORE_DEPTH));
	end

	// frame length and outcome
	always_comb begin
		lenp1  = {1'b0, first_len_q} + 9'd1;
		flen_c = 16'd0;
		stat_c = ST_OK;
		case (op_q)
			OP_PING, OP_ACTION, OP_RESET: begin
				flen_c = 16'd2;
			end
			OP_READ: begin
				flen_c = 16'd4;
			end
			OP_WRITE, OP_REGW: begin
				flen_c = 16'(first_len_q) + 16'd3;
				if (flen_c > 16'(MAX_LEN)) begin
					stat_c = ST_OVERFLOW;
				end else if (bir_q < first_len_q) begin
					stat_c = ST_INVALID;
				end
			end
			OP_SYNC: begin
				flen_c = prod_q + 16'd4;
				if (rc_q == 7'd0) begin
					stat_c = ST_INVALID;
				end else if (flen_c > 16'(MAX_LEN)) begin
					stat_c = ST_OVERFLOW;
				end else if (err_q || bir_q < first_len_q) begin
					stat_c = ST_INVALID;
				end
			end
			default: begin
				stat_c = ST_INVALID;
			end
		endcase
	end

	assign raddr    = e_q;
	assign last_idx = ADDR_W'(flen_q + ADDR_W'(3));
	assign err_word = (state_q == S_DEC) && (stat_c != ST_OK);

	// byte select for the word whose store read was registered alongside idx_s1
	always_comb begin
		if (idx_s1 == last_idx) begin
			byte_c = ~sum_q;
		end else if (idx_s1 == ADDR_W'(0) || idx_s1 == ADDR_W'(1)) begin
			byte_c = HDR_BYTE;
		end else if (idx_s1 == ADDR_W'(2)) begin
			byte_c = id_q;
		end else if (idx_s1 == ADDR_W'(3)) begin
			byte_c = 8'(flen_q);
		end else if (idx_s1 == ADDR_W'(4)) begin
			byte_c = instr_code(op_q);
		end else begin
			byte_c = rdata;
		end
	end

	sbfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(fp_q[ADDR_W-1:0]),
		.wdata(put_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fp_q        <= '0;
			sum_q       <= 8'd0;
			first_reg_q <= 8'd0;
			first_len_q <= 8'd0;
			rc_q        <= 7'd0;
			bir_q       <= 8'd0;
			err_q       <= 1'b0;
			op_q        <= OP_PING;
			id_q        <= 8'd0;
			last_q      <= 1'b0;
			mask_q      <= 4'd0;
			word_q      <= '0;
			prod_q      <= 16'd0;
			flen_q      <= '0;
			e_q         <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			strobe      <= 1'b0;
			result      <= '0;
		end else begin
			v_s1   <= (state_q == S_EMIT);
			strobe <= v_s1 || err_word;
			if (v_s1) begin
				result.tx_byte   <= byte_c;
				result.status    <= ST_OK;
				result.frame_end <= (idx_s1 == last_idx);
			end else if (err_word) begin
				result.tx_byte   <= 8'd0;
				result.status    <= stat_c;
				result.frame_end <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (idle_c) begin
							fp_q  <= FILL_W'(5);
							sum_q <= hdr_id + instr_code(cmd.operation);
							op_q  <= cmd.operation;
							id_q  <= hdr_id;
						end
						first_reg_q <= new_rec ? cmd.reg_addr : flr_e;
						first_len_q <= fln_a;
						rc_q        <= rc_a;
						bir_q       <= mask_c[3] ? bir_a + 8'd1 : bir_a;
						err_q       <= err_e || (sync_rs && (rc_e != 7'd0) &&
						               (bir_e < fln_e || cmd.reg_addr != flr_e ||
						               cmd.data_len != fln_e));
						last_q      <= cmd.command_last;
						mask_q      <= mask_c;
						word_q      <= cmd;
						if (mask_c != 4'd0) begin
							state_q <= S_PUT;
						end else if (cmd.command_last) begin
							state_q <= S_MUL;
						end
					end
				end
				S_PUT: begin
					if (we) begin
						fp_q  <= fp_q + FILL_W'(1);
						sum_q <= sum_q + put_byte;
					end
					mask_q <= mask_nxt;
					if (mask_nxt == 4'd0) begin
						state_q <= last_q ? S_MUL : S_IDLE;
					end
				end
				S_MUL: begin
					prod_q  <= 16'(rc_q) * 16'(lenp1);
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (stat_c == ST_OK) begin
						flen_q  <= flen_c[ADDR_W-1:0];
						sum_q   <= sum_q + flen_c[7:0];
						e_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						fp_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					idx_s1 <= e_q;
					e_q    <= e_q + ADDR_W'(1);
					if (e_q == last_idx) begin
						fp_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.frame_end && result.tx_byte == 8'd0)
		else $error("error word without frame end or with nonzero byte");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= FILL_W'(STORE_DEPTH))
		else $error("fill pointer past store depth");

	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.frame_end |=> !strobe)
		else $error("word right after frame end");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> e_q <= last_idx)
		else $error("emit index past checksum");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == S_EMIT || state_q == S_IDLE)
		else $error("readout overlaps item loading");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for servo_bus_frame_builder, directed and random commands
// predicts every frame word in the bench and compares each strobed word in order
// depends on sbfb_pkg and the servo_bus_frame_builder rtl
`timescale 1ns / 100ps

module tb_top
	import sbfb_pkg::*;
();

	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam int FLAW_EMPTY    = 0;
	localparam int FLAW_NOISE    = 1;
	localparam int FLAW_MISMATCH = 2;
	localparam int FLAW_SHORT    = 3;
	localparam int FLAW_OVERFLOW = 4;
	localparam int FLAW_NONE     = 5;

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic strobe;
	rsp_t result;

	servo_bus_frame_builder uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	always #5 clk = ~clk;

	// frame image and assembly state of the predictor
	logic [7:0] frame_img [STORE_DEPTH];
	int         img_fill;
	logic [7:0] img_sum;
	logic [7:0] img_reg;
	logic [7:0] img_len;
	int         img_records;
	int         img_rec_bytes;
	logic [1:0] img_err;
	rsp_t       frames_due[$];

	int idle_pct = 14;
	int items_used = 0;
	int commands_sent = 0;
	int frames_built = 0;
	int error_words = 0;
	int words_compared = 0;
	int fails = 0;
	int stall_count = 0;
	rsp_t want;

	function void clear_image();
		img_fill = 0;
		img_sum = 8'h00;
		img_reg = 8'h00;
		img_len = 8'h00;
		img_records = 0;
		img_rec_bytes = 0;
		img_err = ST_OK;
	endfunction

	function void stash_byte(input logic [7:0] v);
		if (img_fill < STORE_DEPTH) begin
			frame_img[img_fill] = v;
			img_sum = img_sum + v;
			img_fill++;
		end
	endfunction

	// returns 1 when the word changes the frame or closes the command
	function bit build_frame(input cmd_t w);
		logic [7:0] ins;
		int flen;
		logic [1:0] st;
		bit used;
		rsp_t r;
		used = w.command_last;
		flen = 0;
		st = ST_OK;
		if (img_fill == 0) begin
			clear_image();
			used = 1'b1;
			frame_img[0] = HDR_BYTE;
			frame_img[1] = HDR_BYTE;
			frame_img[2] = (w.operation == OP_SYNC) ? ALL_CALL_ID : w.servo_id;
			frame_img[3] = 8'h00;
			case (w.operation)
				OP_PING:   frame_img[4] = INS_PING;
				OP_READ:   frame_img[4] = INS_READ;
				OP_WRITE:  frame_img[4] = INS_WRITE;
				OP_REGW:   frame_img[4] = INS_REGW;
				OP_ACTION: frame_img[4] = INS_ACTION;
				OP_RESET:  frame_img[4] = INS_RESET;
				OP_SYNC:   frame_img[4] = SYNC_INSTR;
				default:   frame_img[4] = INS_NONE;
			endcase
			img_sum = frame_img[2] + frame_img[4];
			img_fill = 5;
			img_err = (w.operation == OP_UNUSED) ? ST_INVALID : ST_OK;
			if (w.operation == OP_READ) begin
				stash_byte(w.reg_addr);
				stash_byte(w.data_len);
			end else if (w.operation == OP_WRITE || w.operation == OP_REGW) begin
				img_reg = w.reg_addr;
				img_len = w.data_len;
				stash_byte(w.reg_addr);
				img_records = 1;
			end
		end
		ins = frame_img[4];

		if (ins == SYNC_INSTR && w.record_start) begin
			used = 1'b1;
			if (img_records == 0) begin
				img_reg = w.reg_addr;
				img_len = w.data_len;
				stash_byte(w.reg_addr);
				stash_byte(w.data_len);
			end else if (img_rec_bytes < img_len || w.reg_addr != img_reg
					|| w.data_len != img_len) begin
				img_err = ST_INVALID;
			end
			if (img_records < 127)
				img_records++;
			stash_byte(w.servo_id);
			img_rec_bytes = 0;
		end
		if ((ins == INS_WRITE || ins == INS_REGW || ins == SYNC_INSTR)
				&& img_records > 0 && img_rec_bytes < img_len) begin
			used = 1'b1;
			stash_byte(w.data_byte);
			img_rec_bytes++;
		end

		if (!w.command_last)
			return used;

		case (ins)
			INS_PING, INS_ACTION, INS_RESET: flen = 2;
			INS_READ: flen = 4;
			INS_WRITE, INS_REGW: begin
				flen = img_len + 3;
				if (flen > MAX_LEN)
					st = ST_OVERFLOW;
				else if (img_rec_bytes < img_len)
					st = ST_INVALID;
			end
			SYNC_INSTR: begin
				if (img_records == 0) begin
					st = ST_INVALID;
				end else begin
					flen = img_records * (img_len + 1) + 4;
					if (flen > MAX_LEN)
						st = ST_OVERFLOW;
					else if (img_err != ST_OK || img_rec_bytes < img_len)
						st = ST_INVALID;
				end
			end
			default: st = ST_INVALID;
		endcase

		if (st == ST_OK) begin
			frame_img[3] = flen[7:0];
			img_sum = img_sum + flen[7:0];
			frame_img[flen + 3] = ~img_sum;
			for (int i = 0; i < flen + 4; i++) begin
				r.tx_byte = frame_img[i];
				r.status = ST_OK;
				r.frame_end = (i == flen + 3);
				frames_due.push_back(r);
			end
			frames_built++;
		end else begin
			r.tx_byte = 8'h00;
			r.status = st;
			r.frame_end = 1'b1;
			frames_due.push_back(r);
			error_words++;
		end
		clear_image();
		return used;
	endfunction

	function void check_field(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, result);
				fails++;
			end else begin
				want = frames_due.pop_front();
				check_field("tx_byte", want.tx_byte, result.tx_byte);
				check_field("status", 8'(want.status), 8'(result.status));
				check_field("frame_end", 8'(want.frame_end), 8'(result.frame_end));
				words_compared++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe === 1'b1) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("servo_bus_frame_builder verification failed");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	function automatic cmd_t mk_word(input logic [2:0] op, input logic [7:0] id, rg, ln, dt,
			input logic rs, lst);
		cmd_t w;
		w.operation = op;
		w.servo_id = id;
		w.reg_addr = rg;
		w.data_len = ln;
		w.data_byte = dt;
		w.record_start = rs;
		w.command_last = lst;
		return w;
	endfunction

	function automatic cmd_t rand_word();
		cmd_t w;
		w.operation = 3'($urandom_range(7));
		w.servo_id = 8'($urandom_range(255));
		w.reg_addr = 8'($urandom_range(255));
		w.data_len = 8'($urandom_range(255));
		w.data_byte = 8'($urandom_range(255));
		w.record_start = 1'($urandom_range(1));
		w.command_last = 1'b0;
		return w;
	endfunction

	task automatic send_word(input cmd_t w);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy !== 1'b0);
		if (build_frame(w))
			items_used++;
		if (w.command_last)
			commands_sent++;
	endtask

	task automatic send_command(input cmd_t seq[$]);
		seq[seq.size() - 1].command_last = 1'b1;
		foreach (seq[k])
			send_word(seq[k]);
	endtask

	task automatic wait_all_frames();
		start <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
	endtask

	task automatic random_simple(input logic [2:0] op, input bit broken);
		cmd_t seq[$];
		int n;
		n = broken ? $urandom_range(4, 2) : 1;
		repeat (n)
			seq.push_back(rand_word());
		seq[0].operation = op;
		send_command(seq);
	endtask

	task automatic random_write(input logic [2:0] op, input bit broken);
		cmd_t seq[$];
		cmd_t w;
		int pick, len, items;
		pick = $urandom_range(99);
		if (pick < 80)
			len = $urandom_range(8, 0);
		else if (pick < 95)
			len = $urandom_range(57, 9);
		else
			len = $urandom_range(255, 58);
		items = (len == 0) ? 1 : len;
		if (len > MAX_LEN - 3)
			items = $urandom_range(3, 1);
		else if (broken)
			items = $urandom_range(items + 2, 1);
		for (int k = 0; k < items; k++) begin
			w = rand_word();
			if (k == 0) begin
				w.operation = op;
				w.data_len = len[7:0];
			end
			seq.push_back(w);
		end
		send_command(seq);
	endtask

	task automatic random_sync(input bit broken);
		cmd_t seq[$];
		cmd_t w;
		logic [7:0] rg;
		int flaw, len, most, recs, bad_rec, items;
		flaw = broken ? $urandom_range(FLAW_OVERFLOW, FLAW_EMPTY) : FLAW_NONE;
		case (flaw)
			FLAW_SHORT:    len = $urandom_range(5, 2);
			FLAW_OVERFLOW: len = $urandom_range(20, 3);
			default:       len = ($urandom_range(9) == 0) ? $urandom_range(20, 6)
					: $urandom_range(5, 0);
		endcase
		most = (MAX_LEN - 4) / (len + 1);
		if (flaw == FLAW_OVERFLOW)
			recs = most + 1 + $urandom_range(1);
		else
			recs = $urandom_range((most < 6) ? most : 6, (flaw == FLAW_MISMATCH) ? 2 : 1);
		bad_rec = $urandom_range(recs - 1);
		if (flaw == FLAW_MISMATCH && bad_rec == 0)
			bad_rec = 1;
		rg = 8'($urandom_range(255));
		if (flaw == FLAW_EMPTY || flaw == FLAW_NOISE) begin
			repeat ($urandom_range(3, 1)) begin
				w = rand_word();
				w.record_start = 1'b0;
				seq.push_back(w);
			end
		end
		if (flaw != FLAW_EMPTY) begin
			for (int r = 0; r < recs; r++) begin
				items = (len == 0) ? 1 : len;
				if (flaw == FLAW_SHORT && r == bad_rec)
					items--;
				for (int k = 0; k < items; k++) begin
					w = rand_word();
					w.record_start = (k == 0);
					if (k == 0) begin
						w.reg_addr = rg;
						w.data_len = len[7:0];
						if (flaw == FLAW_MISMATCH && r == bad_rec) begin
							if ($urandom_range(1))
								w.reg_addr ^= 8'h01 << $urandom_range(7);
							else
								w.data_len ^= 8'h01 << $urandom_range(7);
						end
					end
					seq.push_back(w);
				end
			end
		end
		seq[0].operation = OP_SYNC;
		send_command(seq);
	endtask

	task automatic random_command();
		int pick;
		pick = $urandom_range(99);
		if (pick < 3)
			random_simple(OP_UNUSED, $urandom_range(9) == 0);
		else if (pick < 35)
			random_sync($urandom_range(99) < 20);
		else if (pick < 50)
			random_write(OP_WRITE, $urandom_range(9) == 0);
		else if (pick < 62)
			random_write(OP_REGW, $urandom_range(9) == 0);
		else if (pick < 72)
			random_simple(OP_READ, $urandom_range(9) == 0);
		else if (pick < 82)
			random_simple(OP_PING, $urandom_range(9) == 0);
		else if (pick < 91)
			random_simple(OP_ACTION, $urandom_range(9) == 0);
		else
			random_simple(OP_RESET, $urandom_range(9) == 0);
	endtask

	task automatic test_basic_ops();
		send_word(mk_word(OP_PING, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
		send_word(mk_word(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		send_word(mk_word(OP_ACTION, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
		// extra words after the opening one are ignored
		send_word(mk_word(OP_RESET, 8'hFE, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0));
		send_word(mk_word(OP_UNUSED, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b1));
	endtask

	task automatic test_write_frames();
		send_word(mk_word(OP_WRITE, 8'h03, 8'h00, 8'h00, 8'h77, 1'b0, 1'b1));
		send_word(mk_word(OP_REGW, 8'h04, 8'h1E, 8'h02, 8'h11, 1'b0, 1'b0));
		send_word(mk_word(OP_PING, 8'h99, 8'h00, 8'h00, 8'h22, 1'b1, 1'b1));
		// data beyond the record length is dropped
		send_word(mk_word(OP_WRITE, 8'h7F, 8'h80, 8'h01, 8'hFF, 1'b0, 1'b0));
		send_word(mk_word(OP_SYNC, 8'h10, 8'h20, 8'h30, 8'h00, 1'b0, 1'b1));
	endtask

	task automatic test_bad_commands();
		send_word(mk_word(OP_WRITE, 8'h05, 8'h10, 8'd58, 8'h01, 1'b0, 1'b1));
		send_word(mk_word(OP_REGW, 8'h06, 8'h10, 8'h03, 8'h01, 1'b0, 1'b1));
		send_word(mk_word(OP_UNUSED, 8'h07, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
		send_word(mk_word(OP_SYNC, 8'h08, 8'h00, 8'h01, 8'h00, 1'b0, 1'b1));
	endtask

	task automatic test_sync_frames();
		send_word(mk_word(OP_SYNC, 8'h05, 8'h1E, 8'h01, 8'h10, 1'b1, 1'b0));
		send_word(mk_word(OP_SYNC, 8'h06, 8'h1E, 8'h01, 8'h20, 1'b1, 1'b1));
		// words ahead of the first record are ignored
		send_word(mk_word(OP_SYNC, 8'h09, 8'h33, 8'h44, 8'h55, 1'b0, 1'b0));
		send_word(mk_word(OP_PING, 8'h07, 8'h40, 8'h00, 8'h00, 1'b1, 1'b1));
		// record with a different start register
		send_word(mk_word(OP_SYNC, 8'h01, 8'h20, 8'h01, 8'h01, 1'b1, 1'b0));
		send_word(mk_word(OP_SYNC, 8'h02, 8'h21, 8'h01, 8'h02, 1'b1, 1'b1));
		send_word(mk_word(OP_SYNC, 8'h01, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1));
		// record closes short of its length
		send_word(mk_word(OP_SYNC, 8'h01, 8'h10, 8'h02, 8'h05, 1'b1, 1'b1));
	endtask

	task automatic test_random_traffic(input int pct, input int count);
		int target;
		idle_pct = pct;
		target = items_used + count;
		while (items_used < target)
			random_command();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_ops();
		test_write_frames();
		test_bad_commands();
		test_sync_frames();
		test_random_traffic(14, 135);
		wait_all_frames();
		test_random_traffic(77, 135);
		wait_all_frames();
		test_random_traffic(0, 130);
		wait_all_frames();
		repeat (16) @(posedge clk);
		$display("covered %0d commands with %0d significant words, sender idle 14/77/0 pct",
			commands_sent, items_used);
		$display("%0d frames and %0d error words predicted, %0d result words compared",
			frames_built, error_words, words_compared);
		if (frames_due.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, frames_due.size());
			fails++;
		end
		if (fails == 0)
			$display("servo_bus_frame_builder verification clean");
		else
			$display("servo_bus_frame_builder verification failed");
		$finish;
	end

endmodule
